FILE: rtl/nearest_point_classifier_macros.svh
// Assertion macros for the nearest point classifier.
`ifndef NEAREST_POINT_CLASSIFIER_MACROS_SVH
`define NEAREST_POINT_CLASSIFIER_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define NPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define NPC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/npc_pkg.sv
// Shared types and constants for the nearest point classifier.
`timescale 1ns / 1ps
package npc_pkg;

    localparam int DEFAULT_ENTRIES = 32;
    localparam int COORD_W         = 16;
    localparam int SLOT_W          = 5;
    localparam int DIST_W          = 34;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PLACE_AT   = 2'd0,
        PLACE_NEAR = 2'd1,
        PLACE_SIDE = 2'd2
    } place_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUTER,
        ST_OLOAD,
        ST_INNER,
        ST_MUL,
        ST_ACC,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/nearest_point_classifier.sv
// Nearest point classifier: point table, pairwise rescan and nearest query.
// One item is accepted when start is high and busy is low; busy stays high until the
// item is finished. A query returns one result, marked by done for one cycle, which
// the receiver must take in that cycle. A query walks the table slot by slot and each
// valid slot passes through the single squaring multiplier (one axis per cycle
// plus the accumulate and compare). A query with fewer than two points answers
// without a scan. An in-range add or delete that leaves at least two points
// rescans all pairs through the same unit. Add, delete and unused opcodes give
// no result.
`timescale 1ns / 1ps
`include "nearest_point_classifier_macros.svh"
module nearest_point_classifier #(
    parameter int ENTRIES = npc_pkg::DEFAULT_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        opcode,
    input  logic [npc_pkg::SLOT_W-1:0]        slot,
    input  logic signed [npc_pkg::COORD_W-1:0] pos_x,
    input  logic signed [npc_pkg::COORD_W-1:0] pos_y,
    input  logic signed [npc_pkg::COORD_W-1:0] pos_z,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    output logic                              done,
    output logic                              found,
    output logic [npc_pkg::SLOT_W-1:0]        nearest_slot,
    output logic [1:0]                        placement,
    output logic [npc_pkg::DIST_W-1:0]        distance_sq
);
    import npc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int PT_W  = 3 * COORD_W;

    logic [PT_W-1:0]  mem [ENTRIES];
    logic [PT_W-1:0]  rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;

    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 enable_reg;
    logic [COORD_W-1:0]   ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [IDX_W:0]       i_reg, i_next, j_reg, j_next;
    logic [1:0]           axis_reg, axis_next;
    logic [DIST_W-1:0]    prod_reg, prod_next, acc_reg, acc_next;
    logic [DIST_W-1:0]    best_reg, best_next, min_reg, min_next;
    logic [IDX_W-1:0]     best_slot_reg, best_slot_next;
    logic                 have_reg, have_next, query_reg, query_next;
    logic                 done_reg, done_next, found_reg, found_next;
    logic [SLOT_W-1:0]    near_reg, near_next;
    place_t               place_reg, place_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;

    logic                 accept;
    logic                 in_range;
    logic [IDX_W-1:0]     slot_idx;
    logic [CNT_W-1:0]     count_after;
    logic [COORD_W-1:0]   a_sel, b_sel;
    logic signed [COORD_W:0] diff;
    logic signed [2*COORD_W+1:0] sq;
    logic [DIST_W-1:0]    dsum;
    logic                 better;
    logic [DIST_W+1:0]    best_x4;
    logic [DIST_W+6:0]    best_x121, min_x100;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(slot) < ENTRIES);
    assign slot_idx = IDX_W'(slot);

    always_comb
    begin
        count_after = count_reg;
        if (opcode_t'(opcode) == OP_ADD && in_range && !valid_reg[slot_idx])
            count_after = count_reg + CNT_W'(1);
        else if (opcode_t'(opcode) == OP_DEL && in_range && valid_reg[slot_idx])
            count_after = count_reg - CNT_W'(1);
    end

    assign rd_addr = (state_reg == ST_OUTER) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign mem_we  = accept && (opcode_t'(opcode) == OP_ADD) && in_range;
    assign wr_addr = slot_idx;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {pos_z, pos_y, pos_x};
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    begin a_sel = ax_reg; b_sel = rdata_reg[COORD_W-1:0]; end
            2'd1:    begin a_sel = ay_reg; b_sel = rdata_reg[2*COORD_W-1:COORD_W]; end
            default: begin a_sel = az_reg; b_sel = rdata_reg[PT_W-1:2*COORD_W]; end
        endcase
    end

    assign diff   = $signed({a_sel[COORD_W-1], a_sel}) - $signed({b_sel[COORD_W-1], b_sel});
    assign sq     = diff * diff;
    assign dsum   = acc_reg + prod_reg;
    assign better = !have_reg || (dsum < best_reg);

    assign best_x4   = {best_reg, 2'b00};
    assign best_x121 = {7'd0, best_reg} * 41'd121;
    assign min_x100  = {7'd0, min_reg} * 41'd100;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode_t'(opcode)) inside
                        OP_ADD, OP_DEL:
                            if (in_range && count_after >= CNT_W'(2))
                                state_next = ST_OUTER;
                        OP_QUERY:
                            if (count_reg >= CNT_W'(2))
                                state_next = ST_INNER;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUTER:
            begin
                if (i_reg == (IDX_W+1)'(ENTRIES))
                    state_next = ST_FINISH;
                else if (valid_reg[i_reg[IDX_W-1:0]])
                    state_next = ST_OLOAD;
            end
            ST_OLOAD: state_next = ST_INNER;
            ST_INNER:
            begin
                if (j_reg == (IDX_W+1)'(ENTRIES))
                    state_next = query_reg ? ST_FINISH : ST_OUTER;
                else if (valid_reg[j_reg[IDX_W-1:0]])
                    state_next = ST_MUL;
            end
            ST_MUL:    if (axis_reg == 2'd2) state_next = ST_ACC;
            ST_ACC:    state_next = ST_INNER;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        valid_next     = valid_reg;
        count_next     = count_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        axis_next      = axis_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        have_next      = have_reg;
        query_next     = query_reg;
        min_next       = min_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        near_next      = near_reg;
        place_next     = place_reg;
        dist_next      = dist_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    have_next  = 1'b0;
                    query_next = (opcode_t'(opcode) == OP_QUERY);
                    ax_next    = pos_x;
                    ay_next    = pos_y;
                    az_next    = pos_z;
                    if (in_range && opcode_t'(opcode) == OP_ADD)
                        valid_next[slot_idx] = 1'b1;
                    if (in_range && opcode_t'(opcode) == OP_DEL)
                        valid_next[slot_idx] = 1'b0;
                    if (in_range)
                        count_next = count_after;
                    if (opcode_t'(opcode) == OP_QUERY && count_reg < CNT_W'(2))
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        near_next  = '0;
                        place_next = PLACE_AT;
                        dist_next  = '0;
                    end
                end
            end
            ST_OUTER:
                if (i_reg != (IDX_W+1)'(ENTRIES) && !valid_reg[i_reg[IDX_W-1:0]])
                    i_next = i_reg + 1'b1;
            ST_OLOAD:
            begin
                ax_next = rdata_reg[COORD_W-1:0];
                ay_next = rdata_reg[2*COORD_W-1:COORD_W];
                az_next = rdata_reg[PT_W-1:2*COORD_W];
                j_next  = i_reg + 1'b1;
            end
            ST_INNER:
            begin
                axis_next = 2'd0;
                if (j_reg == (IDX_W+1)'(ENTRIES))
                    i_next = i_reg + 1'b1;
                else if (!valid_reg[j_reg[IDX_W-1:0]])
                    j_next = j_reg + 1'b1;
            end
            ST_MUL:
            begin
                prod_next = DIST_W'($unsigned(sq));
                acc_next  = (axis_reg == 2'd0) ? '0 : dsum;
                axis_next = axis_reg + 2'd1;
            end
            ST_ACC:
            begin
                if (better)
                begin
                    best_next      = dsum;
                    best_slot_next = j_reg[IDX_W-1:0];
                    have_next      = 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (query_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    near_next  = SLOT_W'(best_slot_reg);
                    dist_next  = best_reg;
                    if (!enable_reg || best_x4 < {2'b00, min_reg})
                        place_next = PLACE_AT;
                    else if (best_x121 < min_x100)
                        place_next = PLACE_NEAR;
                    else
                        place_next = PLACE_SIDE;
                end
                else
                    min_next = best_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            count_reg  <= '0;
            min_reg    <= '0;
            enable_reg <= 1'b1;
            done_reg   <= 1'b0;
            have_reg   <= 1'b0;
            query_reg  <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            axis_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            if (cfg_we)
                enable_reg <= cfg_wdata;
            done_reg  <= done_next;
            have_reg  <= have_next;
            query_reg <= query_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        found_reg     <= found_next;
        near_reg      <= near_next;
        place_reg     <= place_next;
        dist_reg      <= dist_next;
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign nearest_slot = near_reg;
    assign placement    = place_reg;
    assign distance_sq  = dist_reg;

    `NPC_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
    `NPC_ASSERT(a_found_count, done && found |-> count_reg >= CNT_W'(2), "found with too few points")
    `NPC_NEVER(a_count_range, count_reg > CNT_W'(ENTRIES), "point count beyond table size")
    `NPC_ASSERT(a_query_busy, start && !busy && opcode == OP_QUERY && count_reg >= CNT_W'(2) |=> busy,
        "query did not start a scan")

endmodule

FILE: tb/nearest_point_classifier_test.sv
// Testbench for nearest_point_classifier: directed table plus random traffic.
`timescale 1ns / 1ps
module nearest_point_classifier_test;
    import npc_pkg::*;

    typedef struct packed {
        logic        found;
        logic [4:0]  nslot;
        logic [1:0]  place;
        logic [33:0] dsq;
    } answer_t;

    typedef struct {
        opcode_t     op;
        logic [4:0]  slt;
        logic [15:0] x, y, z;
        logic        known;
        answer_t     ans;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] opcode = 0;
    logic [4:0] slot = 0;
    logic signed [15:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic cfg_we = 0, cfg_wdata = 0;
    logic done, found;
    logic [4:0] nearest_slot;
    logic [1:0] placement;
    logic [33:0] distance_sq;

    nearest_point_classifier u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .slot(slot), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .found(found),
        .nearest_slot(nearest_slot), .placement(placement), .distance_sq(distance_sq)
    );

    always #6 clk = ~clk;

    bit            tbl_valid [32];
    logic signed [15:0] tbl_x [32], tbl_y [32], tbl_z [32];
    logic [33:0]   min_pair;
    int            n_points;
    bit            class_en;
    answer_t       pending_answers[$];
    int            errors = 0;
    bit            no_idle = 0;

    function automatic logic [63:0] sq_dist(logic signed [15:0] ax, ay, az, bx, by, bz);
        longint dx, dy, dz;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        dz = longint'(az) - longint'(bz);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic void rescan_pairs();
        logic [63:0] best, d;
        bit have;
        n_points = 0;
        foreach (tbl_valid[i]) if (tbl_valid[i]) n_points++;
        if (n_points < 2) return;
        have = 0;
        best = 0;
        for (int i = 0; i < 32; i++)
            for (int j = i + 1; j < 32; j++)
                if (tbl_valid[i] && tbl_valid[j]) begin
                    d = sq_dist(tbl_x[i], tbl_y[i], tbl_z[i], tbl_x[j], tbl_y[j], tbl_z[j]);
                    if (!have || d < best) begin
                        best = d;
                        have = 1;
                    end
                end
        min_pair = best[33:0];
    endfunction

    // returns 1 when the item yields a result
    function automatic bit predict_item(opcode_t op, logic [4:0] s, logic signed [15:0] x, y, z,
                                        output answer_t a);
        logic [63:0] best, d, m;
        bit have;
        a = '0;
        if (op == OP_ADD || op == OP_DEL) begin
            tbl_valid[s] = (op == OP_ADD);
            if (op == OP_ADD) begin
                tbl_x[s] = x;
                tbl_y[s] = y;
                tbl_z[s] = z;
            end
            rescan_pairs();
            return 0;
        end
        if (op != OP_QUERY) return 0;
        if (n_points < 2) return 1;
        have = 0;
        best = 0;
        for (int i = 0; i < 32; i++)
            if (tbl_valid[i]) begin
                d = sq_dist(x, y, z, tbl_x[i], tbl_y[i], tbl_z[i]);
                if (!have || d < best) begin
                    best = d;
                    a.nslot = 5'(i);
                    have = 1;
                end
            end
        m = min_pair;
        a.found = 1;
        a.dsq = best[33:0];
        if (!class_en || 4 * best < m) a.place = PLACE_AT;
        else if (121 * best < 100 * m) a.place = PLACE_NEAR;
        else a.place = PLACE_SIDE;
        return 1;
    endfunction

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && done) begin
            if (pending_answers.size() == 0) begin
                $error("result with no pending query");
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, found);
                    errors++;
                end
                if (nearest_slot !== e.nslot) begin
                    $error("nearest_slot exp %0d got %0d", e.nslot, nearest_slot);
                    errors++;
                end
                if (placement !== e.place) begin
                    $error("placement exp %0d got %0d", e.place, placement);
                    errors++;
                end
                if (distance_sq !== e.dsq) begin
                    $error("distance_sq exp %0d got %0d", e.dsq, distance_sq);
                    errors++;
                end
            end
        end
    end

    task automatic idle_burst();
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send(opcode_t op, logic [4:0] s, logic [15:0] x, y, z,
                        bit known = 0, answer_t typed = '0);
        answer_t a;
        bit has;
        start <= 1;
        opcode <= op;
        slot <= s;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do @(posedge clk); while (busy);
        has = predict_item(op, s, x, y, z, a);
        if (has) begin
            if (known && a !== typed) begin
                $error("predictor disagrees with typed row");
                errors++;
            end
            pending_answers = {pending_answers, a};
        end
        idle_burst();
    endtask

    task automatic write_class(bit v);
        start <= 0;
        while (pending_answers.size() != 0) @(posedge clk);
        do @(posedge clk); while (busy);
        repeat (4) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        class_en = v;
    endtask

    function automatic logic [15:0] rnd_coord(int span);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    row_t directed[$];

    initial
    begin
        int nslots;
        logic [15:0] cx, cy, cz;
        class_en = 1;
        min_pair = 0;
        n_points = 0;
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed = '{
            '{OP_QUERY, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1, '0},
            '{OP_ADD, 5'd0, 16'h8000, 16'h8000, 16'h8000, 0, '0},
            '{OP_QUERY, 5'd3, 16'h7fff, 16'h7fff, 16'h7fff, 1, '0},
            '{OP_ADD, 5'd31, 16'h7fff, 16'h7fff, 16'h7fff, 0, '0},
            '{OP_QUERY, 5'd0, 16'h8000, 16'h8000, 16'h8000, 1,
              '{1'b1, 5'd0, PLACE_AT, 34'd0}},
            '{OP_QUERY, 5'd0, 16'h7fff, 16'h7fff, 16'h7fff, 1,
              '{1'b1, 5'd31, PLACE_AT, 34'd0}},
            '{OP_QUERY, 5'd0, 16'h7fff, 16'h8000, 16'h8000, 1,
              '{1'b1, 5'd0, PLACE_NEAR, 34'd4294836225}},
            '{OP_QUERY, 5'd0, 16'h0000, 16'h0000, 16'h0000, 0, '0},
            '{OP_ADD, 5'd5, 16'd100, 16'd0, 16'd0, 0, '0},
            '{OP_ADD, 5'd6, 16'd200, 16'd0, 16'd0, 0, '0},
            '{OP_QUERY, 5'd0, 16'd150, 16'd0, 16'd0, 0, '0},
            '{OP_QUERY, 5'd0, 16'd120, 16'd0, 16'd0, 0, '0},
            '{OP_QUERY, 5'd0, 16'd140, 16'd0, 16'd0, 0, '0},
            '{OP_ADD, 5'd6, 16'd100, 16'd0, 16'd0, 0, '0},
            '{OP_QUERY, 5'd0, 16'd100, 16'd0, 16'd0, 0, '0},
            '{OP_DEL, 5'd6, 16'hffff, 16'hffff, 16'hffff, 0, '0},
            '{OP_DEL, 5'd9, 16'h0, 16'h0, 16'h0, 0, '0},
            '{OP_NONE, 5'd0, 16'h0, 16'h0, 16'h0, 0, '0},
            '{OP_QUERY, 5'd0, 16'h5555, 16'haaaa, 16'h1234, 0, '0},
            '{OP_DEL, 5'd31, 16'h0, 16'h0, 16'h0, 0, '0},
            '{OP_DEL, 5'd0, 16'h0, 16'h0, 16'h0, 0, '0},
            '{OP_QUERY, 5'd0, 16'h0, 16'h0, 16'h0, 1, '0}
        };
        foreach (directed[i])
            send(directed[i].op, directed[i].slt, directed[i].x, directed[i].y, directed[i].z,
                 directed[i].known, directed[i].ans);

        for (int phase = 0; phase < 6; phase++) begin
            write_class(phase % 3 != 1);
            if (phase == 5) no_idle = 1;
            nslots = (phase % 2) ? 32 : 8;
            for (int k = 0; k < 180; k++) begin
                int r;
                r = $urandom_range(0, 99);
                cx = rnd_coord(400);
                cy = rnd_coord(400);
                cz = rnd_coord(400);
                if (r < 20) send(OP_ADD, 5'($urandom_range(0, nslots - 1)), cx, cy, cz);
                else if (r < 28) send(OP_DEL, 5'($urandom_range(0, nslots - 1)), cx, cy, cz);
                else if (r < 30) send(OP_NONE, 5'($urandom), cx, cy, cz);
                else send(OP_QUERY, 5'($urandom), cx, cy, cz);
            end
        end
        start <= 0;

        fork
            begin
                while (pending_answers.size() != 0) @(posedge clk);
                do @(posedge clk); while (busy);
                repeat (20) @(posedge clk);
            end
            begin
                repeat (3000000) @(posedge clk);
                $display("nearest_point_classifier_test NOT OK");
                $finish;
            end
        join_any
        if (errors == 0)
            $display("nearest_point_classifier_test OK");
        else
            $display("nearest_point_classifier_test NOT OK");
        $finish;
    end

    initial
    begin
        #500ms;
        $display("nearest_point_classifier_test NOT OK");
        $finish;
    end
endmodule
